### sv/smld_pkg.sv
// shared types and constants of the sync-marker length deframer
package smld_pkg;

  localparam int MarkerBytes = 16;
  localparam int SizeBytes   = 8;
  localparam int HdrBytes    = MarkerBytes + SizeBytes;
  localparam int WinW        = MarkerBytes * 8;
  localparam int FillW       = $clog2(MarkerBytes + 1);
  localparam int HdrCntW     = $clog2(HdrBytes);
  localparam int SizeCntW    = $clog2(SizeBytes);
  localparam logic [31:0] MaxLenReset = 32'd1048576;

  typedef enum logic [1:0] {
    KIND_PACK   = 2'd0,
    KIND_END    = 2'd1,
    KIND_BUFFER = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SIZE = 2'd1,
    PH_HDR  = 2'd2,
    PH_DATA = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    CFG_PACK_LO   = 3'd0,
    CFG_PACK_HI   = 3'd1,
    CFG_END_LO    = 3'd2,
    CFG_END_HI    = 3'd3,
    CFG_BUFFER_LO = 3'd4,
    CFG_BUFFER_HI = 3'd5,
    CFG_MAX_LEN   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [127:0] pack;
    logic [127:0] fin;
    logic [127:0] buffer;
  } marker_set_t;

  typedef struct packed {
    logic  hit;
    kind_e kind;
  } match_t;

endpackage

### sv/smld_match.sv
// whole-window compare against the three sync markers, with priority
module smld_match (
  input  logic [smld_pkg::WinW-1:0] window_i,
  input  smld_pkg::marker_set_t     markers_i,
  output smld_pkg::match_t          match_o
);
  import smld_pkg::*;

  logic hit_pack, hit_end, hit_buffer;

  assign hit_pack   = (window_i == markers_i.pack[WinW-1:0]);
  assign hit_end    = (window_i == markers_i.fin[WinW-1:0]);
  assign hit_buffer = (window_i == markers_i.buffer[WinW-1:0]);

  // data beats end, end beats buffer
  always_comb begin
    match_o.hit  = hit_pack | hit_end | hit_buffer;
    match_o.kind = KIND_BUFFER;
    if (hit_pack) begin
      match_o.kind = KIND_PACK;
    end else if (hit_end) begin
      match_o.kind = KIND_END;
    end
  end

endmodule

### sv/sync_marker_length_deframer_top.sv
// sync-marker / length-field deframer: hunt, size field, header burst, payload
//
// channel  direction  beat                      notes
// s_axis   in         rx_byte                   one stream byte per beat
// m_axis   out        frame_byte + tags         tuser: kind, first, too_long
// cfg      in         register index + value    always ready
//
// hunting, size and payload bytes are taken one per cycle while ready is high, which
// holds while the output register is free or the byte is no payload or last size byte.
// after size byte 8, unless too long, the 24 header beats leave one per cycle from a
// shift line over window and size register; input is held off during that burst.
// reset (rst_ni low, asynchronous) returns to hunting with an empty window.
// downstream stalls stop the header burst and payload input, never hunting.
module sync_marker_length_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  output logic [3:0]  m_axis_tuser,   // [1:0] marker_kind, [2] first_of_frame, [3] too_long
  output logic        m_axis_tlast,   // last_of_frame
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import smld_pkg::*;

  localparam logic [31:0]         HdrLen   = 32'(HdrBytes);
  localparam logic [HdrCntW-1:0]  HdrLast  = HdrCntW'(HdrBytes - 1);
  localparam logic [SizeCntW-1:0] SizeLast = SizeCntW'(SizeBytes - 1);
  localparam logic [FillW-1:0]    FillFull = FillW'(MarkerBytes);

  // configuration
  marker_set_t markers_q;
  logic [31:0] max_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      markers_q <= '0;
      max_len_q <= MaxLenReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PACK_LO:   markers_q.pack[63:0]     <= cfg_data_i;
        CFG_PACK_HI:   markers_q.pack[127:64]   <= cfg_data_i;
        CFG_END_LO:    markers_q.fin[63:0]      <= cfg_data_i;
        CFG_END_HI:    markers_q.fin[127:64]    <= cfg_data_i;
        CFG_BUFFER_LO: markers_q.buffer[63:0]   <= cfg_data_i;
        CFG_BUFFER_HI: markers_q.buffer[127:64] <= cfg_data_i;
        CFG_MAX_LEN:   max_len_q                <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // datapath state
  phase_e              phase_q, phase_d;
  logic [WinW-1:0]     win_q, win_d;
  logic [FillW-1:0]    fill_q, fill_d;
  kind_e               kind_q, kind_d;
  logic [63:0]         size_q, size_d;
  logic [SizeCntW-1:0] size_cnt_q, size_cnt_d;
  logic [HdrCntW-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic                hdr_only_q, hdr_only_d;
  logic [31:0]         left_q, left_d;

  // output register
  logic       out_valid_q;
  logic [7:0] out_byte_q, out_byte_d;
  kind_e      out_kind_q, out_kind_d;
  logic       out_first_q, out_first_d;
  logic       out_last_q, out_last_d;
  logic       out_err_q, out_err_d;
  logic       load_out;

  logic [WinW-1:0] win_shift;
  match_t          match;
  logic            out_free, in_has_out, accept;
  logic [63:0]     size_new;
  logic [31:0]     len_lo;
  logic            len_short, too_long;

  assign win_shift = {s_axis_tdata, win_q[WinW-1:8]};

  smld_match u_match (
    .window_i  (win_shift),
    .markers_i (markers_q),
    .match_o   (match)
  );

  assign out_free   = !out_valid_q || m_axis_tready;
  assign in_has_out = ((phase_q == PH_SIZE) && (size_cnt_q == SizeLast)) ||
                      (phase_q == PH_DATA);
  assign s_axis_tready = (phase_q != PH_HDR) && (out_free || !in_has_out);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // size field is little endian: shift bytes in from the top
  assign size_new  = {s_axis_tdata, size_q[63:8]};
  assign len_lo    = size_new[31:0];
  assign len_short = (len_lo < HdrLen);
  assign too_long  = len_short ? (max_len_q < HdrLen) : (len_lo > max_len_q);

  always_comb begin
    phase_d     = phase_q;
    win_d       = win_q;
    fill_d      = fill_q;
    kind_d      = kind_q;
    size_d      = size_q;
    size_cnt_d  = size_cnt_q;
    hdr_cnt_d   = hdr_cnt_q;
    hdr_only_d  = hdr_only_q;
    left_d      = left_q;
    load_out    = 1'b0;
    out_byte_d  = 8'd0;
    out_kind_d  = kind_q;
    out_first_d = 1'b0;
    out_last_d  = 1'b0;
    out_err_d   = 1'b0;

    unique case (phase_q)
      PH_HUNT: begin
        if (accept) begin
          win_d = win_shift;
          if (fill_q != FillFull) begin
            fill_d = fill_q + 1'b1;
          end
          if ((fill_q >= FillFull - 1'b1) && match.hit) begin
            kind_d     = match.kind;
            phase_d    = PH_SIZE;
            size_cnt_d = '0;
          end
        end
      end
      PH_SIZE: begin
        if (accept) begin
          size_d     = size_new;
          size_cnt_d = size_cnt_q + 1'b1;
          if (size_cnt_q == SizeLast) begin
            if (too_long) begin
              load_out  = 1'b1;
              out_err_d = 1'b1;
              phase_d   = PH_HUNT;
              fill_d    = '0;
            end else begin
              phase_d    = PH_HDR;
              hdr_cnt_d  = '0;
              hdr_only_d = len_short || (len_lo == HdrLen);
              left_d     = len_lo - HdrLen;
            end
          end
        end
      end
      PH_HDR: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_byte_d  = win_q[7:0];
          out_first_d = (hdr_cnt_q == '0);
          out_last_d  = (hdr_cnt_q == HdrLast) && hdr_only_q;
          // marker bytes then size bytes leave through one shift line
          win_d       = {size_q[7:0], win_q[WinW-1:8]};
          size_d      = {8'd0, size_q[63:8]};
          hdr_cnt_d   = hdr_cnt_q + 1'b1;
          if (hdr_cnt_q == HdrLast) begin
            phase_d = hdr_only_q ? PH_HUNT : PH_DATA;
            fill_d  = '0;
          end
        end
      end
      PH_DATA: begin
        if (accept) begin
          load_out   = 1'b1;
          out_byte_d = s_axis_tdata;
          out_last_d = (left_q <= 32'd1);
          if (left_q <= 32'd1) begin
            phase_d = PH_HUNT;
            fill_d  = '0;
          end else begin
            left_d = left_q - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      fill_q      <= '0;
      kind_q      <= KIND_PACK;
      size_cnt_q  <= '0;
      hdr_cnt_q   <= '0;
      hdr_only_q  <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      fill_q     <= fill_d;
      kind_q     <= kind_d;
      size_cnt_q <= size_cnt_d;
      hdr_cnt_q  <= hdr_cnt_d;
      hdr_only_q <= hdr_only_d;
      left_q     <= left_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    size_q <= size_d;
    if (load_out) begin
      out_byte_q  <= out_byte_d;
      out_kind_q  <= out_kind_d;
      out_first_q <= out_first_d;
      out_last_q  <= out_last_d;
      out_err_q   <= out_err_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = {out_err_q, out_first_q, out_kind_q};
  assign m_axis_tlast  = out_last_q;

  // no input is taken during the header burst
  a_no_input_in_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HDR) |-> !s_axis_tready)
    else $error("input accepted during header burst");

  // an output beat is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !load_out)
    else $error("output register overwritten while stalled");

  // the window never counts past its depth
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("window fill out of range");

  // an error beat always sends the block back to hunting
  a_err_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && out_err_d) |=> (phase_q == PH_HUNT) && (fill_q == '0))
    else $error("too-long frame did not return to hunting");

  // the header burst starts with the first-of-frame beat
  a_hdr_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(phase_q == PH_HDR)) |-> (hdr_cnt_q == '0))
    else $error("header burst did not start at its first byte");

endmodule

### tb/testbench.sv
// self-checking testbench for the sync-marker length deframer, directed and random byte streams
module testbench;
  import smld_pkg::*;

  // index past the register list, writes to it must be ignored
  localparam logic [2:0] CfgNoReg = 3'd7;

  typedef enum int {SCAN, SIZE_FIELD, PAYLOAD} scan_state_e;

  typedef struct {
    logic [7:0] data;
    kind_e      kind;
    logic       first;
    logic       last;
    logic       too_long;
  } beat_t;

  class frame_scoreboard;
    logic [7:0]  win [MarkerBytes];
    int          win_fill;
    scan_state_e state;
    kind_e       frame_kind;
    logic [63:0] size_field;
    int          size_cnt;
    logic [31:0] bytes_left;
    logic [63:0] mk_lo [3];
    logic [63:0] mk_hi [3];
    logic [31:0] max_len;
    beat_t       due_beats [$];
    int          n_err;

    function new();
      foreach (win[k]) win[k] = 8'h00;
      for (int m = 0; m < 3; m++) begin
        mk_lo[m] = '0;
        mk_hi[m] = '0;
      end
      max_len    = MaxLenReset;
      frame_kind = KIND_PACK;
      n_err      = 0;
      restart();
    endfunction

    function void restart();
      state      = SCAN;
      win_fill   = 0;
      size_field = '0;
      size_cnt   = 0;
      bytes_left = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        CFG_PACK_LO:   mk_lo[KIND_PACK] = val;
        CFG_PACK_HI:   mk_hi[KIND_PACK] = val;
        CFG_END_LO:    mk_lo[KIND_END] = val;
        CFG_END_HI:    mk_hi[KIND_END] = val;
        CFG_BUFFER_LO: mk_lo[KIND_BUFFER] = val;
        CFG_BUFFER_HI: mk_hi[KIND_BUFFER] = val;
        CFG_MAX_LEN:   max_len = val[31:0];
        default: ;
      endcase
    endfunction

    function bit window_is(kind_e m);
      logic [127:0] mk;
      mk = {mk_hi[m], mk_lo[m]};
      for (int k = 0; k < MarkerBytes; k++)
        if (win[k] !== mk[8*k +: 8]) return 1'b0;
      return 1'b1;
    endfunction

    function void queue_beat(logic [7:0] d, kind_e kd, logic fst, logic lst, logic err);
      beat_t e;
      e.data     = d;
      e.kind     = kd;
      e.first    = fst;
      e.last     = lst;
      e.too_long = err;
      due_beats.insert(due_beats.size(), e);
    endfunction

    // works out the beats that one accepted input byte causes
    function void note_byte(logic [7:0] b);
      logic [31:0] len;
      logic [7:0]  hb;
      case (state)
        SIZE_FIELD: begin
          size_field[8*size_cnt +: 8] = b;
          size_cnt++;
          if (size_cnt == SizeBytes) begin
            len = size_field[31:0];
            if (len < HdrBytes) len = HdrBytes;
            if (len > max_len) begin
              queue_beat(8'h00, frame_kind, 1'b0, 1'b0, 1'b1);
              restart();
            end else begin
              for (int k = 0; k < HdrBytes; k++) begin
                hb = (k < MarkerBytes) ? win[k] : size_field[8*(k-MarkerBytes) +: 8];
                queue_beat(hb, frame_kind, k == 0, (k == HdrBytes - 1) && (len == HdrBytes),
                           1'b0);
              end
              if (len == HdrBytes) begin
                restart();
              end else begin
                bytes_left = len - HdrBytes;
                state      = PAYLOAD;
              end
            end
          end
        end
        PAYLOAD: begin
          queue_beat(b, frame_kind, 1'b0, bytes_left <= 1, 1'b0);
          if (bytes_left <= 1) restart();
          else bytes_left--;
        end
        default: begin
          for (int k = 0; k < MarkerBytes - 1; k++) win[k] = win[k+1];
          win[MarkerBytes-1] = b;
          if (win_fill < MarkerBytes) win_fill++;
          // whole-window compare, data beats end and end beats buffer
          if (win_fill >= MarkerBytes) begin
            if (window_is(KIND_PACK)) begin
              frame_kind = KIND_PACK;
              state      = SIZE_FIELD;
            end else if (window_is(KIND_END)) begin
              frame_kind = KIND_END;
              state      = SIZE_FIELD;
            end else if (window_is(KIND_BUFFER)) begin
              frame_kind = KIND_BUFFER;
              state      = SIZE_FIELD;
            end
            size_field = '0;
            size_cnt   = 0;
          end
        end
      endcase
    endfunction

    function void flag(string msg);
      if (n_err < 10) $display("%s", msg);
      n_err++;
    endfunction

    function void check_beat(logic [7:0] d, logic [3:0] u, logic l);
      beat_t e;
      if (due_beats.size() == 0) begin
        flag($sformatf("unexpected beat: data %h user %h last %b", d, u, l));
        return;
      end
      e = due_beats.pop_front();
      if (d !== e.data || u[1:0] !== e.kind || u[2] !== e.first || l !== e.last ||
          u[3] !== e.too_long)
        flag($sformatf("mismatch d/k/f/l/e: exp %h/%0d/%b/%b/%b got %h/%0d/%b/%b/%b",
                       e.data, e.kind, e.first, e.last, e.too_long,
                       d, u[1:0], u[2], l, u[3]));
    endfunction

    function int pending();
      return due_beats.size();
    endfunction

    function bit mid_frame();
      return state != SCAN;
    endfunction

    function bit in_size_field();
      return state == SIZE_FIELD;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  frame_scoreboard frames;
  logic [63:0] mk_lo [3];
  logic [63:0] mk_hi [3];
  logic [31:0] lim;
  int          n_sent;
  bit          calm_tx;
  bit          calm_rx;
  int          stall_left;

  sync_marker_length_deframer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap(bit calm, int long_max);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, long_max);
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = pick_gap(calm_tx, 30);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    frames.note_byte(b);
    n_sent++;
  endtask

  task automatic send_noise(int n);
    for (int k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_marker(int m, int from, int cnt);
    logic [127:0] mk;
    mk = {mk_hi[m], mk_lo[m]};
    for (int k = from; k < from + cnt; k++) send_byte(mk[8*k +: 8]);
  endtask

  task automatic send_size(logic [63:0] s);
    for (int k = 0; k < SizeBytes; k++) send_byte(s[8*k +: 8]);
  endtask

  function automatic int payload_len(logic [63:0] s);
    logic [31:0] len;
    len = s[31:0];
    if (len < HdrBytes) len = HdrBytes;
    if (len > lim) return 0;
    return int'(len) - HdrBytes;
  endfunction

  task automatic send_frame(int m, logic [63:0] s);
    send_marker(m, 0, MarkerBytes);
    send_size(s);
    send_noise(payload_len(s));
  endtask

  // frame sizes stay small unless they are meant to hit the limit
  function automatic logic [63:0] pick_size();
    logic [31:0] len;
    case ($urandom_range(0, 9))
      0: len = $urandom_range(0, HdrBytes - 1);
      1: len = HdrBytes;
      2: len = (lim < 200) ? lim : HdrBytes + $urandom_range(1, 40);
      3: len = (lim != 32'hFFFF_FFFF) ? lim + 1 : HdrBytes + 1;
      4: len = (lim != 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : HdrBytes + 2;
      default: len = HdrBytes + $urandom_range(1, 40);
    endcase
    return {(($urandom_range(0, 3) == 0) ? $urandom : 32'h0), len};
  endfunction

  task automatic one_sequence();
    int          m;
    int          cut;
    logic [63:0] s;
    m = $urandom_range(0, 2);
    if ($urandom_range(0, 5) == 0) calm_tx = ~calm_tx;
    case ($urandom_range(0, 9))
      0: send_noise(($urandom_range(0, 3) == 0) ? 20 : $urandom_range(1, 5));
      1: begin
        // broken marker: head or tail missing
        cut = $urandom_range(1, MarkerBytes - 1);
        if ($urandom_range(0, 1) == 0) send_marker(m, 0, cut);
        else send_marker(m, cut, MarkerBytes - cut);
        send_noise(1);
      end
      default: begin
        send_noise($urandom_range(0, 2));
        s = pick_size();
        send_marker(m, 0, MarkerBytes);
        send_size(s);
        if (payload_len(s) >= MarkerBytes && $urandom_range(0, 3) == 0) begin
          // a marker inside the payload is plain data
          send_marker($urandom_range(0, 2), 0, MarkerBytes);
          send_noise(payload_len(s) - MarkerBytes);
        end else begin
          send_noise(payload_len(s));
        end
      end
    endcase
  endtask

  task automatic run_random(int target);
    while (n_sent < target) one_sequence();
    while (frames.mid_frame())
      send_byte(frames.in_size_field() ? 8'h00 : 8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (frames.pending() != 0);
  endtask

  // idle stretch so that any stray beat shows up before the next step
  task automatic settle();
    drain();
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    frames.write_reg(idx, val);
  endtask

  task automatic apply_settings(bit stray);
    write_reg(CFG_PACK_LO, mk_lo[KIND_PACK]);
    write_reg(CFG_PACK_HI, mk_hi[KIND_PACK]);
    write_reg(CFG_END_LO, mk_lo[KIND_END]);
    write_reg(CFG_END_HI, mk_hi[KIND_END]);
    write_reg(CFG_BUFFER_LO, mk_lo[KIND_BUFFER]);
    write_reg(CFG_BUFFER_HI, mk_hi[KIND_BUFFER]);
    write_reg(CFG_MAX_LEN, {$urandom, lim});
    if (stray) write_reg(CfgNoReg, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_markers();
    for (int m = 0; m < 3; m++) begin
      mk_lo[m] = {$urandom, $urandom};
      mk_hi[m] = {$urandom, $urandom};
    end
  endtask

  initial begin
    frames        = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_PACK_LO;
    cfg_data_i    = '0;
    calm_tx       = 1'b0;
    n_sent        = 0;
    for (int m = 0; m < 3; m++) begin
      mk_lo[m] = '0;
      mk_hi[m] = '0;
    end
    lim = MaxLenReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset markers are all zero and equal, so zero runs are data-packet markers
    send_frame(KIND_PACK, '1);
    settle();

    // distinct markers, widest limit
    random_markers();
    lim = 32'hFFFF_FFFF;
    apply_settings(1'b1);
    send_noise(3);
    send_marker(KIND_END, 0, MarkerBytes);
    send_size(64'(HdrBytes + 18));
    send_marker(KIND_BUFFER, 0, MarkerBytes);
    send_noise(2);
    // marker head at the end of a frame must not join its tail after the frame
    send_marker(KIND_PACK, 0, MarkerBytes);
    send_size(64'(HdrBytes + 8));
    send_marker(KIND_PACK, 0, 8);
    send_marker(KIND_PACK, 8, 8);
    send_frame(KIND_BUFFER, {32'h8000_0001, 32'd25});
    settle();

    // all-ones and all-zeros markers, tightest legal limit
    random_markers();
    mk_lo[KIND_PACK] = '1;
    mk_hi[KIND_PACK] = '1;
    mk_lo[KIND_END]  = '0;
    mk_hi[KIND_END]  = '0;
    lim = HdrBytes;
    apply_settings(1'b0);
    send_frame(KIND_PACK, 64'(HdrBytes + 1));
    send_frame(KIND_END, 64'd7);
    settle();

    // three equal markers always report a data packet
    random_markers();
    mk_lo[KIND_END]    = mk_lo[KIND_PACK];
    mk_hi[KIND_END]    = mk_hi[KIND_PACK];
    mk_lo[KIND_BUFFER] = mk_lo[KIND_PACK];
    mk_hi[KIND_BUFFER] = mk_hi[KIND_PACK];
    lim = $urandom_range(HdrBytes, 120);
    apply_settings(1'b0);
    run_random(n_sent + 1);
    drain();
    run_random(n_sent + 1);
    settle();

    // end equals buffer, limit below the header length
    random_markers();
    mk_lo[KIND_BUFFER] = mk_lo[KIND_END];
    mk_hi[KIND_BUFFER] = mk_hi[KIND_END];
    lim = $urandom_range(0, HdrBytes - 1);
    apply_settings(1'b0);
    send_frame(KIND_END, '0);

    drain();
    repeat (60) @(posedge clk_i);
    if (frames.n_err == 0 && frames.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // result side: random stalls with calm stretches
  initial begin
    stall_left = 0;
    calm_rx    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        frames.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if ($urandom_range(0, 149) == 0) calm_rx = ~calm_rx;
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap(calm_rx, 30);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

### sync_marker_length_deframer_top.f
sv/smld_pkg.sv
sv/smld_match.sv
sv/sync_marker_length_deframer_top.sv
tb/testbench.sv
